// ===== rtl/core/rgb_to_hsl_converter_macros.svh =====
// assertion macros shared by the rgb to hsl converter checkers
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// same-cycle implication, off while reset is high
`define RHC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhc check failed");

// next-cycle implication, off while reset is high
`define RHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhc check failed");

`endif

// ===== rtl/core/rhc_pkg.sv =====
// shared types and constants for the rgb to hsl converter
package rhc_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned SAT_W = 16;
  localparam int unsigned SUM_W = 9;

  // divider geometry: 24-bit numerator, 8-bit divisor, 16 quotient bits
  localparam int unsigned DEN_W          = 8;
  localparam int unsigned QUO_W          = 16;
  localparam int unsigned NUM_W          = DEN_W + QUO_W;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  // hue in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_GREEN  = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE   = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;

  // which component is largest; red wins ties over green, green over blue
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // per-pixel side information carried alongside the dividers
  typedef struct packed {
    sector_t          sector;
    logic             neg;
    logic             grey;
    logic [SUM_W-1:0] sum;
  } side_t;

endpackage

// ===== rtl/core/rgb_to_hsl_converter.sv =====
// rgb to hsl converter top level: one pixel per clock while m_axis is not stalled, pipelined dividers
//
//   channel   direction  tdata fields (lowest bit up)
//   s_axis    in         red[7:0] green[15:8] blue[23:16]
//   m_axis    out        hue[14:0] saturation[30:15] lightness_sum[39:31]
//
// eleven register stages: min/max, numerators, eight divider stages of two
// quotient bits each, then hue assembly into the output register.
// one pixel per cycle is sustained while m_axis_tready stays high. rst
// clears all valid bits; data registers are not reset. each stage holds
// while the stage after it is full and stalled, so bubbles are squeezed
// out and input keeps flowing while a result waits, until they are gone.
module rgb_to_hsl_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // hue[14:0], saturation[30:15], lightness_sum[39:31]
);

  localparam int unsigned DIV_BASE = 2;
  localparam int unsigned LAST     = DIV_BASE + rhc_pkg::DIV_STAGES;
  localparam int unsigned STAGES   = LAST + 1;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  // stall chain: a stage loads when it is empty or the next one loads
  always_comb begin
    adv[LAST] = !vld[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 0: max, min, sector and hue difference
  logic [rhc_pkg::PIX_W-1:0] red;
  logic [rhc_pkg::PIX_W-1:0] green;
  logic [rhc_pkg::PIX_W-1:0] blue;
  logic [rhc_pkg::PIX_W-1:0] mx;
  logic [rhc_pkg::PIX_W-1:0] mn;
  logic [rhc_pkg::PIX_W-1:0] dp;
  logic [rhc_pkg::PIX_W-1:0] dm;
  rhc_pkg::side_t            side_next;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  always_comb begin
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    priority if (red >= green && red >= blue) begin
      mx               = red;
      side_next.sector = rhc_pkg::SECT_RED;
      dp               = green;
      dm               = blue;
    end else if (green >= blue) begin
      mx               = green;
      side_next.sector = rhc_pkg::SECT_GREEN;
      dp               = blue;
      dm               = red;
    end else begin
      mx               = blue;
      side_next.sector = rhc_pkg::SECT_BLUE;
      dp               = red;
      dm               = green;
    end
    side_next.neg  = (dp < dm);
    side_next.grey = (mx == mn);
    side_next.sum  = {1'b0, mx} + {1'b0, mn};
  end

  rhc_pkg::side_t            side [LAST];
  logic [rhc_pkg::PIX_W-1:0] chroma0;
  logic [rhc_pkg::PIX_W-1:0] absd0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      chroma0 <= mx - mn;
      absd0   <= side_next.neg ? (dm - dp) : (dp - dm);
    end
  end

  // stage 1: numerators and saturation divisor
  logic [rhc_pkg::NUM_W-1:0] sat_num;
  logic [rhc_pkg::NUM_W-1:0] hue_num;
  logic [rhc_pkg::DEN_W-1:0] sat_den;
  logic [rhc_pkg::DEN_W-1:0] hue_den;
  logic [rhc_pkg::SUM_W-1:0] flip_sum;
  logic [19:0]               hue_prod;

  assign flip_sum = 9'd510 - side[0].sum;
  assign hue_prod = 20'(absd0) * 20'(rhc_pkg::HUE_SECTOR);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      // chroma * 65535
      sat_num <= {chroma0, 16'd0} - {16'd0, chroma0};
      hue_num <= {4'd0, hue_prod};
      sat_den <= (side[0].sum <= 9'd255) ? side[0].sum[7:0] : flip_sum[7:0];
      hue_den <= chroma0;
    end
  end

  // divider stages, side data travels in step
  logic [rhc_pkg::QUO_W-1:0] sat_quo;
  logic [rhc_pkg::QUO_W-1:0] hue_quo;

  rhc_div u_sat_div (
    .clk (clk),
    .adv (adv[LAST-1:DIV_BASE]),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  rhc_div u_hue_div (
    .clk (clk),
    .adv (adv[LAST-1:DIV_BASE]),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  // side data moves with every stage up to the output
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side[0] <= side_next;
    end
    for (int k = 1; k < LAST; k++) begin
      if (adv[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // last stage: signed offset, sector base and wrap
  rhc_pkg::side_t            sd;
  logic [rhc_pkg::HUE_W-1:0] q;
  logic [rhc_pkg::HUE_W-1:0] hue_next;

  assign sd = side[LAST-1];
  assign q  = hue_quo[rhc_pkg::HUE_W-1:0];

  always_comb begin
    unique case (sd.sector)
      rhc_pkg::SECT_RED: begin
        hue_next = (sd.neg && q != '0) ? (rhc_pkg::HUE_FULL - q) : q;
      end
      rhc_pkg::SECT_GREEN: begin
        hue_next = sd.neg ? (rhc_pkg::HUE_GREEN - q) : (rhc_pkg::HUE_GREEN + q);
      end
      rhc_pkg::SECT_BLUE: begin
        hue_next = sd.neg ? (rhc_pkg::HUE_BLUE - q) : (rhc_pkg::HUE_BLUE + q);
      end
      default: begin
        hue_next = '0;
      end
    endcase
  end

  logic [rhc_pkg::HUE_W-1:0] hue;
  logic [rhc_pkg::SAT_W-1:0] saturation;
  logic [rhc_pkg::SUM_W-1:0] lightness_sum;

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      hue           <= sd.grey ? '0 : hue_next;
      saturation    <= sd.grey ? '0 : sat_quo;
      lightness_sum <= sd.sum;
    end
  end

  assign m_axis_tvalid = vld[LAST];
  assign m_axis_tdata  = {lightness_sum, saturation, hue};

endmodule

// ===== rtl/core/rhc_div.sv =====
// pipelined restoring divider, two quotient bits per stage
module rhc_div (
  input  logic                                clk,
  input  logic [rhc_pkg::DIV_STAGES-1:0]      adv,   // per-stage load enables
  input  logic [rhc_pkg::NUM_W-1:0]           num,   // num < den * 2**QUO_W
  input  logic [rhc_pkg::DEN_W-1:0]           den,
  output logic [rhc_pkg::QUO_W-1:0]           quo
);

  localparam int unsigned RQ_W = rhc_pkg::DEN_W + rhc_pkg::QUO_W;

  // partial remainder in the top bits, numerator bits shifting out and
  // quotient bits shifting in below it
  logic [RQ_W-1:0]          rq  [rhc_pkg::DIV_STAGES];
  logic [rhc_pkg::DEN_W-1:0] dv [rhc_pkg::DIV_STAGES];

  // one shift-compare-subtract step
  function automatic logic [RQ_W-1:0] div_step(input logic [RQ_W-1:0] rq_in,
                                               input logic [rhc_pkg::DEN_W-1:0] d);
    logic [rhc_pkg::DEN_W:0] t;
    logic [rhc_pkg::DEN_W:0] diff;
    logic                    ge;
    t        = {rq_in[RQ_W-1:rhc_pkg::QUO_W], rq_in[rhc_pkg::QUO_W-1]};
    ge       = (t >= {1'b0, d});
    diff     = t - {1'b0, d};
    div_step = {(ge ? diff[rhc_pkg::DEN_W-1:0] : t[rhc_pkg::DEN_W-1:0]),
                rq_in[rhc_pkg::QUO_W-2:0], ge};
  endfunction

  for (genvar j = 0; j < rhc_pkg::DIV_STAGES; j++) begin : g_stage
    logic [RQ_W-1:0]           rq_src;
    logic [RQ_W-1:0]           rq_next;
    logic [rhc_pkg::DEN_W-1:0] dv_src;

    // stage input: the numerator itself or the previous stage
    if (j == 0) begin : g_first
      assign rq_src = num;
      assign dv_src = den;
    end else begin : g_rest
      assign rq_src = rq[j-1];
      assign dv_src = dv[j-1];
    end

    always_comb begin
      rq_next = rq_src;
      for (int s = 0; s < rhc_pkg::BITS_PER_STAGE; s++) begin
        rq_next = div_step(rq_next, dv_src);
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rq[j] <= rq_next;
        dv[j] <= dv_src;
      end
    end
  end

  assign quo = rq[rhc_pkg::DIV_STAGES-1][rhc_pkg::QUO_W-1:0];

endmodule

// ===== rtl/core/rhc_checker.sv =====
// port-level checks for the rgb to hsl converter, bound to the top level
`include "rgb_to_hsl_converter_macros.svh"

module rhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [rhc_pkg::HUE_W-1:0] hue;
  logic [rhc_pkg::SAT_W-1:0] saturation;
  logic [rhc_pkg::SUM_W-1:0] lightness_sum;

  assign hue           = m_axis_tdata[14:0];
  assign saturation    = m_axis_tdata[30:15];
  assign lightness_sum = m_axis_tdata[39:31];

  // a stalled result transfer keeps its data
  `RHC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // hue stays below one full turn
  `RHC_ASSERT_IMPLY(a_hue_range, clk, rst, m_axis_tvalid, hue < rhc_pkg::HUE_FULL)

  // zero saturation only for grey pixels, which carry hue zero
  `RHC_ASSERT_IMPLY(a_grey_hue, clk, rst, m_axis_tvalid && saturation == '0, hue == '0)

  // max plus min never exceeds twice full scale
  `RHC_ASSERT_IMPLY(a_sum_range, clk, rst, m_axis_tvalid, lightness_sum <= 9'd510)

endmodule

bind rgb_to_hsl_converter rhc_checker u_rhc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
